// ===== rtl/scaf_pkg.sv =====
package scaf_pkg;

  localparam int BUF_DEPTH_DEF = 16;

  localparam logic [7:0] SC_SHIFT_DOWN = 8'h2A;
  localparam logic [7:0] SC_SHIFT_UP   = 8'h2A + 8'd128;
  localparam logic [7:0] SC_CAPS       = 8'h3A;
  localparam logic [7:0] SC_RELEASE    = 8'd128;
  localparam logic [7:0] CHAR_LOWER_A  = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFFSET   = 8'h20;

  typedef enum logic {
    OP_SCAN = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] scancode;
  } req_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       char_valid;
    logic [3:0] fill_count;
    logic       dropped;
  } res_t;

  typedef struct packed {
    logic       push;
    logic [7:0] ch;
  } push_t;

  function automatic logic [7:0] key_char(input logic [7:0] code);
    logic [7:0] c;
    case (code)
      8'd0:  c = 8'h3F;  8'd1:  c = 8'h3F;  8'd2:  c = 8'h31;  8'd3:  c = 8'h32;
      8'd4:  c = 8'h33;  8'd5:  c = 8'h34;  8'd6:  c = 8'h35;  8'd7:  c = 8'h36;
      8'd8:  c = 8'h37;  8'd9:  c = 8'h38;  8'd10: c = 8'h39;  8'd11: c = 8'h30;
      8'd12: c = 8'h2D;  8'd13: c = 8'h3D;  8'd14: c = 8'h08;  8'd15: c = 8'h3F;
      8'd16: c = 8'h71;  8'd17: c = 8'h77;  8'd18: c = 8'h65;  8'd19: c = 8'h72;
      8'd20: c = 8'h74;  8'd21: c = 8'h79;  8'd22: c = 8'h75;  8'd23: c = 8'h69;
      8'd24: c = 8'h6F;  8'd25: c = 8'h70;  8'd26: c = 8'h5B;  8'd27: c = 8'h5D;
      8'd28: c = 8'h0A;  8'd29: c = 8'h3F;  8'd30: c = 8'h61;  8'd31: c = 8'h73;
      8'd32: c = 8'h64;  8'd33: c = 8'h66;  8'd34: c = 8'h67;  8'd35: c = 8'h68;
      8'd36: c = 8'h6A;  8'd37: c = 8'h6B;  8'd38: c = 8'h6C;  8'd39: c = 8'h3B;
      8'd40: c = 8'h27;  8'd41: c = 8'h60;  8'd42: c = 8'h3F;  8'd43: c = 8'h5C;
      8'd44: c = 8'h7A;  8'd45: c = 8'h78;  8'd46: c = 8'h63;  8'd47: c = 8'h76;
      8'd48: c = 8'h62;  8'd49: c = 8'h6E;  8'd50: c = 8'h6D;  8'd51: c = 8'h2C;
      8'd52: c = 8'h2E;  8'd53: c = 8'h2F;  8'd54: c = 8'h3F;  8'd55: c = 8'h3F;
      8'd56: c = 8'h3F;  8'd57: c = 8'h20;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/scancode_to_ascii_fifo.sv =====
// An accepted request has its result registered for the cycle after it.
// Throughput: one request per cycle while res_ready is high; the character
// store is a one-port-read, one-port-write RAM; pops use its registered read.
// Reset clears shift, caps lock, both ring pointers and the fill count.
// Character store contents are not cleared.
module scancode_to_ascii_fifo #(
  parameter int BUF_DEPTH = scaf_pkg::BUF_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  scaf_pkg::req_t req,
  output logic           res_valid,
  input  logic           res_ready,
  output scaf_pkg::res_t res
);

  localparam int AW = $clog2(BUF_DEPTH);
  localparam logic [AW-1:0] LAST = AW'(BUF_DEPTH - 1);

  logic            accept;
  scaf_pkg::push_t push;
  logic            empty;
  logic            full;
  logic            do_pop;
  logic            do_push;
  logic            drop;
  logic [AW-1:0]   read_ptr;
  logic [AW-1:0]   write_ptr;
  logic [AW-1:0]   count;
  logic [AW-1:0]   count_next;
  logic [AW+3:0]   fill_ext;
  logic [7:0]      rdata;
  logic            char_valid;
  logic [3:0]      fill_count;
  logic            dropped;

  assign req_ready = ~res_valid | res_ready;
  assign accept    = req_valid & req_ready;

  scaf_keymap u_keymap (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .req    (req),
    .push   (push)
  );

  always_comb begin
    empty   = (count == '0);
    full    = (count == LAST);
    do_pop  = accept && (req.op == scaf_pkg::OP_POP) && !empty;
    do_push = push.push && !full;
    drop    = push.push && full;
    count_next = count;
    if (do_push) begin
      count_next = count + AW'(1);
    end else if (do_pop) begin
      count_next = count - AW'(1);
    end
    fill_ext = {4'b0000, count_next};
  end

  scaf_ram #(
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (write_ptr),
    .wdata (push.ch),
    .re    (do_pop),
    .raddr (read_ptr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      read_ptr  <= '0;
      write_ptr <= '0;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (do_pop) begin
        read_ptr <= (read_ptr == LAST) ? '0 : read_ptr + AW'(1);
      end
      if (do_push) begin
        write_ptr <= (write_ptr == LAST) ? '0 : write_ptr + AW'(1);
      end
      if (accept) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      char_valid <= do_pop;
      fill_count <= fill_ext[3:0];
      dropped    <= drop;
    end
  end

  always_comb begin
    res.char_out   = char_valid ? rdata : 8'h00;
    res.char_valid = char_valid;
    res.fill_count = fill_count;
    res.dropped    = dropped;
  end

endmodule

// ===== rtl/scaf_keymap.sv =====
module scaf_keymap (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  scaf_pkg::req_t  req,
  output scaf_pkg::push_t push
);

  logic       shift_held;
  logic       caps_on;
  logic [7:0] raw;
  logic       is_lower;

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_held <= 1'b0;
      caps_on    <= 1'b0;
    end else if (accept && req.op == scaf_pkg::OP_SCAN) begin
      if (req.scancode == scaf_pkg::SC_SHIFT_DOWN) begin
        shift_held <= 1'b1;
      end else if (req.scancode == scaf_pkg::SC_SHIFT_UP) begin
        shift_held <= 1'b0;
      end else if (req.scancode == scaf_pkg::SC_CAPS) begin
        caps_on <= ~caps_on;
      end
    end
  end

  always_comb begin
    raw      = scaf_pkg::key_char(req.scancode);
    is_lower = (raw >= scaf_pkg::CHAR_LOWER_A) && (raw <= scaf_pkg::CHAR_LOWER_Z);
    push.ch  = (is_lower && (shift_held != caps_on)) ? raw - scaf_pkg::CASE_OFFSET : raw;
    push.push = accept && (req.op == scaf_pkg::OP_SCAN)
                && (req.scancode < scaf_pkg::SC_RELEASE)
                && (req.scancode != scaf_pkg::SC_SHIFT_DOWN)
                && (req.scancode != scaf_pkg::SC_CAPS);
  end

endmodule

// ===== rtl/scaf_ram.sv =====
module scaf_ram #(
  parameter int DEPTH = scaf_pkg::BUF_DEPTH_DEF,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== dv/scancode_to_ascii_fifo_tb.sv =====
`timescale 1ns / 100ps

module scancode_to_ascii_fifo_tb;

  localparam int DEPTH    = scaf_pkg::BUF_DEPTH_DEF;
  localparam int MAP_LEN  = 58;
  localparam int LIMIT    = 300000;
  localparam int N_RANDOM = 1425;
  localparam int HOLD_LEN = 300;
  // set-1 key map, codes 0..57; backspace and enter patched in key_ascii
  localparam logic [MAP_LEN*8-1:0] KEYS =
    "??1234567890-=_?qwertyuiop[]_?asdfghjkl;'`?\\zxcvbnm,./??? ";

  typedef struct packed {
    scaf_pkg::req_t rq;
    logic           typed;
    scaf_pkg::res_t want;
  } dir_row_t;

  logic           clk;
  logic           rst;
  logic           req_valid;
  logic           req_ready;
  scaf_pkg::req_t req;
  logic           res_valid;
  logic           res_ready;
  scaf_pkg::res_t res;

  logic           shift_on;
  logic           caps_lock;
  logic [7:0]     held_chars[$];
  scaf_pkg::res_t pending_res[$];

  int cycles;
  int errs;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_ask;
  int hold_left;
  int n_sent;
  int n_keys;
  int n_drops;
  int n_got_chars;
  int n_empty_pops;
  int n_stall_cycles;

  dir_row_t dir_rows[25] = '{
    '{'{scaf_pkg::OP_POP,  8'h00}, 1'b1, '{8'h00, 1'b0, 4'd0,  1'b0}},
    '{'{scaf_pkg::OP_SCAN, 8'h00}, 1'b1, '{8'h00, 1'b0, 4'd1,  1'b0}},
    '{'{scaf_pkg::OP_SCAN, 8'h39}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h3A}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h10}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h2A}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h10}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h3A}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h1E}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h02}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'hAA}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h3B}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h7F}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h80}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'hFF}, 1'b0, '0},
    '{'{scaf_pkg::OP_POP,  8'hFF}, 1'b1, '{8'h3F, 1'b1, 4'd7,  1'b0}},
    '{'{scaf_pkg::OP_SCAN, 8'h0E}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h1C}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h2C}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h19}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h2B}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h29}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h35}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h01}, 1'b0, '0},
    '{'{scaf_pkg::OP_SCAN, 8'h32}, 1'b1, '{8'h00, 1'b0, 4'd15, 1'b1}}
  };

  scancode_to_ascii_fifo u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [7:0] key_ascii(input logic [7:0] code);
    int idx;
    idx = code;
    if (idx >= MAP_LEN) return 8'h00;
    if (idx == 14) return 8'h08;
    if (idx == 28) return 8'h0A;
    return KEYS[(MAP_LEN - 1 - idx)*8 +: 8];
  endfunction

  function automatic void decode_request(input scaf_pkg::req_t r,
                                         output scaf_pkg::res_t o);
    logic [7:0] c;
    o = '0;
    if (r.op == scaf_pkg::OP_POP) begin
      if (held_chars.size() != 0) begin
        o.char_out   = held_chars.pop_front();
        o.char_valid = 1'b1;
        n_got_chars++;
      end else begin
        n_empty_pops++;
      end
    end else if (r.scancode == scaf_pkg::SC_SHIFT_DOWN) begin
      shift_on = 1'b1;
    end else if (r.scancode == scaf_pkg::SC_SHIFT_UP) begin
      shift_on = 1'b0;
    end else if (r.scancode == scaf_pkg::SC_CAPS) begin
      caps_lock = ~caps_lock;
    end else if (r.scancode < scaf_pkg::SC_RELEASE) begin
      c = key_ascii(r.scancode);
      if (c >= "a" && c <= "z" && shift_on != caps_lock) c = c - ("a" - "A");
      n_keys++;
      if (held_chars.size() == DEPTH - 1) begin
        o.dropped = 1'b1;
        n_drops++;
      end else begin
        held_chars.push_back(c);
      end
    end
    o.fill_count = 4'(held_chars.size());
  endfunction

  function automatic scaf_pkg::req_t rand_request(input int pop_pct);
    scaf_pkg::req_t r;
    int             k;
    r.scancode = 8'($urandom);
    if ($urandom_range(99) < pop_pct) begin
      r.op = scaf_pkg::OP_POP;
    end else begin
      r.op = scaf_pkg::OP_SCAN;
      k = $urandom_range(99);
      if (k < 6)       r.scancode = scaf_pkg::SC_SHIFT_DOWN;
      else if (k < 12) r.scancode = scaf_pkg::SC_SHIFT_UP;
      else if (k < 17) r.scancode = scaf_pkg::SC_CAPS;
      else if (k < 75) r.scancode = 8'($urandom_range(MAP_LEN - 1));
      else if (k < 85) r.scancode = 8'($urandom_range(127, MAP_LEN));
      else             r.scancode = 8'($urandom_range(255, 128));
    end
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge
  task automatic send_req(input scaf_pkg::req_t r, input logic typed,
                          input scaf_pkg::res_t want);
    scaf_pkg::res_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    decode_request(r, p);
    pending_res.push_back(typed ? want : p);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic drain;
    req_valid <= 1'b0;
    while (pending_res.size() != 0) @(negedge clk);
  endtask

  always @(negedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      res_ready <= 1'b0;
      hold_left--;
    end else begin
      res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    scaf_pkg::res_t want;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_res.size());
      $display("FAIL scancode_to_ascii_fifo");
      $finish;
    end
    if (!rst && req_valid && !req_ready) n_stall_cycles++;
    if (!rst && res_valid && res_ready) begin
      if (pending_res.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result %p at cycle %0d", res, cycles);
      end else begin
        want = pending_res.pop_front();
        if (res.char_out !== want.char_out || res.char_valid !== want.char_valid ||
            res.fill_count !== want.fill_count || res.dropped !== want.dropped) begin
          errs++;
          if (errs <= 10)
            $display("mismatch cycle %0d: char %h/%h valid %b/%b fill %0d/%0d drop %b/%b",
                     cycles, want.char_out, res.char_out, want.char_valid,
                     res.char_valid, want.fill_count, res.fill_count,
                     want.dropped, res.dropped);
        end
      end
    end
  end

  initial begin
    int             ph;
    int             n;
    int             chunk_left;
    int             pop_pct;
    scaf_pkg::req_t r;
    rst            = 1'b1;
    req_valid      = 1'b0;
    req            = '0;
    res_ready      = 1'b0;
    shift_on       = 1'b0;
    caps_lock      = 1'b0;
    cycles         = 0;
    errs           = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_ask       = 0;
    hold_left      = 0;
    n_sent         = 0;
    n_keys         = 0;
    n_drops        = 0;
    n_got_chars    = 0;
    n_empty_pops   = 0;
    n_stall_cycles = 0;
    chunk_left     = 0;
    pop_pct        = 50;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].typed, dir_rows[i].want);
    drain();

    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
        default: begin send_idle_pct = 14; recv_stall_pct = 14; end
      endcase
      if (ph == 0) begin
        // long receiver hold-off while requests keep coming
        @(posedge clk);
        hold_ask = HOLD_LEN;
        @(negedge clk);
      end
      for (n = 0; n < N_RANDOM / 4; n++) begin
        if (ph == 1 && n == N_RANDOM / 8) drain();
        if (chunk_left == 0) begin
          chunk_left = $urandom_range(40, 10);
          case ($urandom_range(2))
            0:       pop_pct = 15;
            1:       pop_pct = 50;
            default: pop_pct = 85;
          endcase
        end
        chunk_left--;
        r = rand_request(pop_pct);
        send_req(r, 1'b0, '0);
      end
      drain();
    end

    repeat (8) @(posedge clk);
    $display("%0d requests: %0d key pushes (%0d lost to a full buffer), %0d characters popped",
             n_sent, n_keys, n_drops, n_got_chars);
    $display("%0d pops on an empty buffer, %0d cycles of input back-pressure",
             n_empty_pops, n_stall_cycles);
    if (errs == 0) begin
      $display("PASS scancode_to_ascii_fifo");
    end else begin
      $display("%0d mismatches", errs);
      $display("FAIL scancode_to_ascii_fifo");
    end
    $finish;
  end

endmodule
